// File: rtl/core/rgb_status_glow_controller_assert.svh
// Assertion macros for the status glow controller.
// Both macros expect clk and rst_n in scope at the point of use.
`ifndef RGB_STATUS_GLOW_CONTROLLER_ASSERT_SVH
`define RGB_STATUS_GLOW_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
`define RSG_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("status glow: invariant violated");
`define RSG_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("status glow: sequence violated");
`else
`define RSG_ASSERT_ALWAYS(label, cond)
`define RSG_ASSERT_NEXT(label, pre, post)
`endif

`endif

// File: rtl/core/rgbsg_pkg.sv
package rgbsg_pkg;

    localparam int ROM_DEPTH = 256;
    localparam int PHASE_W   = $clog2(ROM_DEPTH);
    localparam int PACE_W    = 15;
    localparam int TIME_W    = 32;
    localparam int BED_W     = 13;
    localparam int TARGET_W  = 12;
    localparam int HOT_PACE_W = 7;

    typedef logic [7:0]          level_t;
    typedef logic [PHASE_W-1:0]  phase_t;
    typedef logic [PACE_W-1:0]   pace_t;
    typedef logic [TIME_W-1:0]   ms_t;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } colour_t;

    typedef struct packed {
        colour_t ovr_colour;
        pace_t   ovr_pace;
        ms_t     idle_timeout;
    } cfg_t;

    typedef struct packed {
        ms_t                   now_ms;
        logic signed [BED_W-1:0] bed_temp;
        logic [TARGET_W-1:0]   target_temp;
        logic                  is_cooling;
        logic                  temp_change_pending;
        ms_t                   last_rx_ms;
    } poll_t;

    // register indexes on the config port
    localparam logic [2:0] CFG_OVR_RED   = 3'd0;
    localparam logic [2:0] CFG_OVR_GREEN = 3'd1;
    localparam logic [2:0] CFG_OVR_BLUE  = 3'd2;
    localparam logic [2:0] CFG_OVR_PACE  = 3'd3;
    localparam logic [2:0] CFG_IDLE_TMO  = 3'd4;

    localparam ms_t IDLE_TIMEOUT_RST = 32'd60000;
    localparam ms_t PURPLE_WINDOW_MS = 32'd45000;

    localparam logic signed [BED_W-1:0] BED_HOT_LIMIT  = 13'sd500;
    localparam logic signed [BED_W-1:0] BED_WARM_LIMIT = 13'sd400;
    localparam logic signed [BED_W:0]   CEIL_BIAS      = 14'sd83;

    localparam logic [HOT_PACE_W-1:0] HOT_PACE_BASE = 7'd36;
    localparam logic [HOT_PACE_W-1:0] HOT_PACE_MIN  = 7'd5;
    // q >= this limit clamps the hot pace to its minimum
    localparam logic [5:0]            HOT_CLAMP_Q   = 6'd31;

    // floor(y/21) = (y * 3121) >> 16 for y < 1045 (y = x/4, divisor 84)
    localparam logic [11:0] RECIP_21    = 12'd3121;
    localparam int          RECIP_SHIFT = 16;

    localparam int    IDLE_PACE_MS = 30;
    localparam int    QUICK_DIV    = 10;
    localparam pace_t IDLE_PACE    = pace_t'(IDLE_PACE_MS);
    localparam pace_t QUICK_PACE   = pace_t'(IDLE_PACE_MS / QUICK_DIV);

    localparam phase_t RAMP_TURN = phase_t'(128);

    localparam colour_t COL_RED    = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
    localparam colour_t COL_BLUE   = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
    localparam colour_t COL_ORANGE = '{red: 8'd255, green: 8'd40,  blue: 8'd0};
    localparam colour_t COL_PURPLE = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
    localparam colour_t COL_GREEN  = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
    localparam colour_t COL_WHITE  = '{red: 8'd255, green: 8'd255, blue: 8'd255};

    localparam level_t BRIGHTNESS_ROM [ROM_DEPTH] = '{
        8'd43,  8'd45,  8'd48,  8'd51,  8'd53,  8'd56,  8'd58,  8'd61,
        8'd64,  8'd66,  8'd69,  8'd72,  8'd74,  8'd77,  8'd79,  8'd82,
        8'd85,  8'd87,  8'd90,  8'd92,  8'd95,  8'd97,  8'd100, 8'd102,
        8'd105, 8'd107, 8'd110, 8'd112, 8'd115, 8'd117, 8'd120, 8'd122,
        8'd125, 8'd127, 8'd130, 8'd132, 8'd134, 8'd137, 8'd139, 8'd141,
        8'd144, 8'd146, 8'd148, 8'd151, 8'd153, 8'd155, 8'd157, 8'd159,
        8'd162, 8'd164, 8'd166, 8'd168, 8'd170, 8'd172, 8'd174, 8'd176,
        8'd178, 8'd180, 8'd182, 8'd184, 8'd186, 8'd188, 8'd190, 8'd192,
        8'd194, 8'd196, 8'd198, 8'd199, 8'd201, 8'd203, 8'd205, 8'd206,
        8'd208, 8'd209, 8'd211, 8'd213, 8'd214, 8'd216, 8'd217, 8'd219,
        8'd220, 8'd222, 8'd223, 8'd224, 8'd226, 8'd227, 8'd228, 8'd230,
        8'd231, 8'd232, 8'd233, 8'd234, 8'd235, 8'd237, 8'd238, 8'd239,
        8'd240, 8'd241, 8'd242, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246,
        8'd246, 8'd247, 8'd248, 8'd249, 8'd249, 8'd250, 8'd250, 8'd251,
        8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd254, 8'd254,
        8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254,
        8'd254, 8'd253, 8'd253, 8'd253, 8'd252, 8'd252, 8'd251, 8'd251,
        8'd250, 8'd250, 8'd249, 8'd249, 8'd248, 8'd247, 8'd246, 8'd246,
        8'd245, 8'd244, 8'd243, 8'd242, 8'd242, 8'd241, 8'd240, 8'd239,
        8'd238, 8'd237, 8'd235, 8'd234, 8'd233, 8'd232, 8'd231, 8'd230,
        8'd228, 8'd227, 8'd226, 8'd224, 8'd223, 8'd222, 8'd220, 8'd219,
        8'd217, 8'd216, 8'd214, 8'd213, 8'd211, 8'd209, 8'd208, 8'd206,
        8'd205, 8'd203, 8'd201, 8'd199, 8'd198, 8'd196, 8'd194, 8'd192,
        8'd190, 8'd188, 8'd186, 8'd184, 8'd182, 8'd180, 8'd178, 8'd176,
        8'd174, 8'd172, 8'd170, 8'd168, 8'd166, 8'd164, 8'd162, 8'd159,
        8'd157, 8'd155, 8'd153, 8'd151, 8'd148, 8'd146, 8'd144, 8'd141,
        8'd139, 8'd137, 8'd134, 8'd132, 8'd130, 8'd127, 8'd125, 8'd122,
        8'd120, 8'd117, 8'd115, 8'd112, 8'd110, 8'd107, 8'd105, 8'd102,
        8'd100, 8'd97,  8'd95,  8'd92,  8'd90,  8'd87,  8'd85,  8'd82,
        8'd79,  8'd77,  8'd74,  8'd72,  8'd69,  8'd66,  8'd64,  8'd61,
        8'd58,  8'd56,  8'd53,  8'd51,  8'd48,  8'd45,  8'd43,  8'd40
    };

endpackage

// File: rtl/core/rgbsg_decide.sv
`include "rgb_status_glow_controller_assert.svh"

// Priority colour/pace pick, step timer and phase/colour state.
module rgbsg_decide (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                poll_valid,
    input  rgbsg_pkg::poll_t    poll,
    input  rgbsg_pkg::cfg_t     cfg,
    output logic                step,
    output rgbsg_pkg::colour_t  held,
    output rgbsg_pkg::phase_t   phase
);

    rgbsg_pkg::colour_t held_reg, held_next;
    rgbsg_pkg::phase_t  phase_reg, phase_next;
    rgbsg_pkg::ms_t     last_step_reg;

    rgbsg_pkg::colour_t want;
    rgbsg_pkg::pace_t   base_pace, pace;
    logic               quick, ramp_down, ovr_on, hot, warm;
    logic               rx_seen;
    rgbsg_pkg::ms_t     since_rx, since_step;

    logic                 bed_pos;
    logic signed [13:0]   bed_ext, ceil_arg;
    logic [10:0]          quarter;
    logic [22:0]          recip_prod;
    logic [5:0]           q;
    logic [rgbsg_pkg::HOT_PACE_W-1:0] hot_pace;

    // hot pace = max(36 - ceil(bed/84), 5); negative bed rounds toward zero
    always_comb
    begin
        bed_pos    = (poll.bed_temp > 13'sd0);
        bed_ext    = 14'(poll.bed_temp);
        ceil_arg   = bed_pos ? (bed_ext + rgbsg_pkg::CEIL_BIAS) : -bed_ext;
        quarter    = ceil_arg[12:2];
        recip_prod = quarter * rgbsg_pkg::RECIP_21;
        q          = recip_prod[rgbsg_pkg::RECIP_SHIFT+5:rgbsg_pkg::RECIP_SHIFT];
        if (!bed_pos)
            hot_pace = rgbsg_pkg::HOT_PACE_BASE + {1'b0, q};
        else if (q >= rgbsg_pkg::HOT_CLAMP_Q)
            hot_pace = rgbsg_pkg::HOT_PACE_MIN;
        else
            hot_pace = rgbsg_pkg::HOT_PACE_BASE - {1'b0, q};
    end

    always_comb
    begin
        ovr_on   = |{cfg.ovr_colour.red, cfg.ovr_colour.green, cfg.ovr_colour.blue};
        hot      = (poll.bed_temp > rgbsg_pkg::BED_HOT_LIMIT);
        warm     = poll.temp_change_pending || (poll.target_temp != '0)
                   || (poll.bed_temp > rgbsg_pkg::BED_WARM_LIMIT);
        since_rx = poll.now_ms - poll.last_rx_ms;
        rx_seen  = (poll.last_rx_ms != '0);
        quick    = 1'b0;
        if (ovr_on) begin
            want      = cfg.ovr_colour;
            base_pace = cfg.ovr_pace;
        end else if (hot) begin
            want      = rgbsg_pkg::COL_RED;
            base_pace = rgbsg_pkg::pace_t'(hot_pace);
        end else if (warm) begin
            want      = poll.is_cooling ? rgbsg_pkg::COL_BLUE : rgbsg_pkg::COL_ORANGE;
            base_pace = rgbsg_pkg::pace_t'(hot_pace);
        end else if (rx_seen && (since_rx < rgbsg_pkg::PURPLE_WINDOW_MS)) begin
            want      = rgbsg_pkg::COL_PURPLE;
            base_pace = rgbsg_pkg::IDLE_PACE;
            quick     = 1'b1;
        end else if (rx_seen && (since_rx < cfg.idle_timeout)) begin
            want      = rgbsg_pkg::COL_GREEN;
            base_pace = rgbsg_pkg::IDLE_PACE;
            quick     = 1'b1;
        end else begin
            want      = rgbsg_pkg::COL_WHITE;
            base_pace = rgbsg_pkg::IDLE_PACE;
        end
    end

    // quick change: faster pace and run the phase back to zero
    always_comb
    begin
        ramp_down  = quick && (want != held_reg);
        pace       = ramp_down ? rgbsg_pkg::QUICK_PACE : base_pace;
        since_step = poll.now_ms - last_step_reg;
        step       = poll_valid && (since_step > rgbsg_pkg::ms_t'(pace));

        held_next = held_reg;
        if (phase_reg == '0)
            held_next = want;
        if (ramp_down && (phase_reg != '0) && (phase_reg <= rgbsg_pkg::RAMP_TURN))
            phase_next = phase_reg - 1'b1;
        else
            phase_next = phase_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg      <= '0;
            phase_reg     <= '0;
            last_step_reg <= '0;
        end else if (adv && step) begin
            held_reg      <= held_next;
            phase_reg     <= phase_next;
            last_step_reg <= poll.now_ms;
        end
    end

    assign held  = held_reg;
    assign phase = phase_reg;

    `RSG_ASSERT_NEXT(a_latch_at_zero, adv && step && (phase_reg == '0), held_reg == $past(want))
    `RSG_ASSERT_NEXT(a_hold_no_step, !(adv && step), $stable(phase_reg) && $stable(held_reg))
    `RSG_ASSERT_NEXT(a_step_time, adv && step, last_step_reg == $past(poll.now_ms))

endmodule

// File: rtl/core/rgbsg_duty.sv
// Brightness curve lookup scaled by the held colour, /256 per channel.
module rgbsg_duty (
    input  rgbsg_pkg::colour_t held,
    input  rgbsg_pkg::phase_t  phase,
    output rgbsg_pkg::colour_t duty
);

    rgbsg_pkg::level_t w;
    logic [15:0]       prod_r, prod_g, prod_b;

    always_comb
    begin
        w          = rgbsg_pkg::BRIGHTNESS_ROM[phase];
        prod_r     = w * held.red;
        prod_g     = w * held.green;
        prod_b     = w * held.blue;
        duty.red   = prod_r[15:8];
        duty.green = prod_g[15:8];
        duty.blue  = prod_b[15:8];
    end

endmodule

// File: rtl/core/rgb_status_glow_controller.sv
// A request moves from poll_reg through res_valid_reg and out_valid_reg to m_tvalid.
// Throughput: one request per cycle unless a result waits on m_tready; the three register
// stages all move on one enable. A poll whose step timer has not run out gives no result;
// its slot moves on empty. Reset (rst_n low, async): pipeline empty, phase and held colour
// zero, last step time zero, override off, idle timeout 60000 ms.
`include "rgb_status_glow_controller_assert.svh"

module rgb_status_glow_controller (
    input  logic        clk,
    input  logic        rst_n,
    // poll request
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] now_ms, [44:32] bed_temp_tenths, [56:45] target_temp_tenths,
    // [57] is_cooling, [58] temp_change_pending, [90:59] last_rx_ms, [95:91] zero
    input  logic [95:0] s_tdata,
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] red_duty, [15:8] green_duty, [23:16] blue_duty
    output logic [23:0] m_tdata,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rgbsg_pkg::cfg_t    cfg_reg;
    rgbsg_pkg::poll_t   poll_in, poll_reg;
    logic               poll_valid_reg;
    logic               res_valid_reg;
    logic               out_valid_reg;
    rgbsg_pkg::colour_t duty, duty_reg;
    rgbsg_pkg::colour_t held;
    rgbsg_pkg::phase_t  phase;
    logic               step;
    logic               adv;

    // whole pipeline advances unless the output holds a result nobody takes
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // unpack the request
    always_comb
    begin
        poll_in.now_ms              = s_tdata[31:0];
        poll_in.bed_temp            = s_tdata[44:32];
        poll_in.target_temp         = s_tdata[56:45];
        poll_in.is_cooling          = s_tdata[57];
        poll_in.temp_change_pending = s_tdata[58];
        poll_in.last_rx_ms          = s_tdata[90:59];
    end

    // config registers; the user must write them only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ovr_colour   <= '0;
            cfg_reg.ovr_pace     <= '0;
            cfg_reg.idle_timeout <= rgbsg_pkg::IDLE_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgbsg_pkg::CFG_OVR_RED:   cfg_reg.ovr_colour.red   <= cfg_data[7:0];
                rgbsg_pkg::CFG_OVR_GREEN: cfg_reg.ovr_colour.green <= cfg_data[7:0];
                rgbsg_pkg::CFG_OVR_BLUE:  cfg_reg.ovr_colour.blue  <= cfg_data[7:0];
                rgbsg_pkg::CFG_OVR_PACE:  cfg_reg.ovr_pace <= cfg_data[rgbsg_pkg::PACE_W-1:0];
                rgbsg_pkg::CFG_IDLE_TMO:  cfg_reg.idle_timeout <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            poll_valid_reg <= s_tvalid;
            res_valid_reg  <= step;
            out_valid_reg  <= res_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv && s_tvalid)
            poll_reg <= poll_in;
        if (adv)
            duty_reg <= duty;
    end

    // stage 1: decide and step; state updates on the edge the poll leaves
    rgbsg_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .poll_valid (poll_valid_reg),
        .poll       (poll_reg),
        .cfg        (cfg_reg),
        .step       (step),
        .held       (held),
        .phase      (phase)
    );

    // stage 2: duty from the freshly stepped phase and held colour
    rgbsg_duty u_duty (
        .held  (held),
        .phase (phase),
        .duty  (duty)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {duty_reg.blue, duty_reg.green, duty_reg.red};

    // a result only ever follows a step, passed on through res_valid_reg
    `RSG_ASSERT_NEXT(a_result_from_step, !res_valid_reg && adv, !out_valid_reg)
    `RSG_ASSERT_NEXT(a_step_needs_poll, adv && !poll_valid_reg, !res_valid_reg)
    // input is only held off by a waiting result
    `RSG_ASSERT_ALWAYS(a_ready_when_empty, out_valid_reg || s_tready)

endmodule

// File: tb/rgb_status_glow_controller_tb.sv
module rgb_status_glow_controller_tb;
    import rgbsg_pkg::*;

    // Cycles with no request, no result and no register write before the run is abandoned.
    // The longest correct quiet stretch is a long sender gap or stall plus the settle pause.
    localparam int QUIET_LIMIT  = 4000;
    // The pipeline has poll, decide and duty stages; spare ticks cover a poll still in flight.
    localparam int SETTLE_TICKS = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 6;

    // Which priority rule picked the colour; used only for the run summary.
    typedef enum int
    {
        SRC_OVR,
        SRC_HOT,
        SRC_COOL,
        SRC_HEAT,
        SRC_RECENT,
        SRC_READY,
        SRC_IDLE
    } src_e;

    typedef enum logic
    {
        ROW_POLL,
        ROW_CFG
    } row_kind_e;

    // One line of the directed plan: either a poll request or a register write.
    // Rows with typed set carry a result read straight off the spec.
    typedef struct
    {
        row_kind_e   kind;
        poll_t       poll;
        logic [2:0]  idx;
        logic [31:0] val;
        bit          typed;
        bit          fires;
        colour_t     duty;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #1 clk = ~clk;

    rgb_status_glow_controller DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predicted lamp state: own copy of registers and breathing state.
    // ------------------------------------------------------------------
    colour_t ovr_colour   = '0;
    pace_t   ovr_pace     = '0;
    ms_t     idle_tmo     = 32'd60000;
    colour_t held         = '0;
    phase_t  phase        = '0;
    ms_t     last_step_at = '0;

    colour_t duty_q[$];     // expected duty triples, oldest first
    ms_t     cur_ms = '0;   // running poll clock for the random part
    bit      calm = 1'b0;   // set: neither side inserts gaps

    int n_fail    = 0;
    int n_polls   = 0;
    int n_results = 0;
    int n_writes  = 0;
    int n_ramp    = 0;
    int src_hits[7];
    int hold_left = 0;
    int quiet     = 0;

    // Hot pace: max(36 - ceil(bed/84), 5); integer division truncates toward zero.
    function automatic int unsigned heat_pace(int bed);
        int steps;
        steps = (bed > 0) ? (bed + 83) / 84 : -((-bed) / 84);
        return (36 - steps < 5) ? 5 : 36 - steps;
    endfunction

    function automatic level_t dim(level_t w, level_t c);
        logic [15:0] prod;
        prod = w * c;
        return prod[15:8];
    endfunction

    // One poll through the priority rule and the breathing counter.
    // Returns 1 with the duty triple when the poll takes a step.
    function automatic bit glow_step(input poll_t p, output colour_t duty);
        colour_t     want;
        int unsigned pace;
        bit          quick;
        bit          ramp;
        ms_t         since;
        ms_t         elapsed;
        int          bed;
        level_t      w;
        src_e        src;
        bed   = $signed(p.bed_temp);
        since = p.now_ms - p.last_rx_ms;
        quick = 1'b0;
        ramp  = 1'b0;
        duty  = '0;
        if (ovr_colour != '0)
        begin
            want = ovr_colour;
            pace = ovr_pace;
            src  = SRC_OVR;
        end
        else if (bed > 500)
        begin
            want = colour_t'{8'd255, 8'd0, 8'd0};
            pace = heat_pace(bed);
            src  = SRC_HOT;
        end
        else if (p.temp_change_pending || p.target_temp != 0 || bed > 400)
        begin
            want = p.is_cooling ? colour_t'{8'd0, 8'd0, 8'd255} : colour_t'{8'd255, 8'd40, 8'd0};
            pace = heat_pace(bed);
            src  = p.is_cooling ? SRC_COOL : SRC_HEAT;
        end
        else if (p.last_rx_ms != 0 && since < 45000)
        begin
            want  = colour_t'{8'd255, 8'd0, 8'd255};
            pace  = 30;
            quick = 1'b1;
            src   = SRC_RECENT;
        end
        else if (p.last_rx_ms != 0 && since < idle_tmo)
        begin
            want  = colour_t'{8'd0, 8'd255, 8'd0};
            pace  = 30;
            quick = 1'b1;
            src   = SRC_READY;
        end
        else
        begin
            want = colour_t'{8'd255, 8'd255, 8'd255};
            pace = 30;
            src  = SRC_IDLE;
        end
        src_hits[int'(src)]++;

        // purple/green heading to a new colour: faster pace, fade back toward zero
        if (quick && want != held)
        begin
            pace = pace / 10;
            ramp = 1'b1;
        end

        elapsed = p.now_ms - last_step_at;
        if (elapsed <= pace)
            return 1'b0;

        last_step_at = p.now_ms;
        // colour only changes at the bottom of the curve
        if (phase == 0)
        begin
            held = want;
            ramp = 1'b0;
        end
        if (ramp && phase <= 128)
        begin
            phase = phase - 1'b1;
            n_ramp++;
        end
        else
            phase = phase + 1'b1;

        w = BRIGHTNESS_ROM[phase];
        duty.red   = dim(w, held.red);
        duty.green = dim(w, held.green);
        duty.blue  = dim(w, held.blue);
        return 1'b1;
    endfunction

    function automatic poll_t make_poll(ms_t now, int bed, int tgt, bit cool, bit pend, ms_t rx);
        poll_t p;
        p.now_ms              = now;
        p.bed_temp            = bed[BED_W-1:0];
        p.target_temp         = tgt[TARGET_W-1:0];
        p.is_cooling          = cool;
        p.temp_change_pending = pend;
        p.last_rx_ms          = rx;
        return p;
    endfunction

    function automatic plan_row_t poll_row(ms_t now, int bed, int tgt, bit cool, bit pend,
                                           ms_t rx, bit typed = 1'b0, bit fires = 1'b0,
                                           colour_t duty = '0);
        plan_row_t r;
        r.kind  = ROW_POLL;
        r.poll  = make_poll(now, bed, tgt, cool, pend, rx);
        r.idx   = '0;
        r.val   = '0;
        r.typed = typed;
        r.fires = fires;
        r.duty  = duty;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(logic [2:0] idx, logic [31:0] val);
        plan_row_t r;
        r.kind  = ROW_CFG;
        r.poll  = '0;
        r.idx   = idx;
        r.val   = val;
        r.typed = 1'b0;
        r.fires = 1'b0;
        r.duty  = '0;
        return r;
    endfunction

    // Gap length shared by sender and receiver: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Poll clock advance: mostly around the pace, some repeats, some jumps, rare wraps.
    function automatic ms_t step_ms(int unsigned stride);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, stride);
        if (r < 90)
            return $urandom_range(0, 3);
        if (r < 98)
            return $urandom_range(0, 100000);
        return $urandom;
    endfunction

    // Drive one poll request, wait for acceptance, then queue what it should produce.
    task automatic send_poll(input poll_t p, input bit typed = 1'b0, input bit t_fires = 1'b0,
                             input colour_t t_duty = '0);
        bit      fires;
        colour_t duty;
        int      gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, p.last_rx_ms, p.temp_change_pending, p.is_cooling,
                     p.target_temp, p.bed_temp, p.now_ms};
        do
            @(posedge clk);
        while (!s_tready);
        n_polls++;
        fires = glow_step(p, duty);
        if (typed)
        begin
            fires = t_fires;
            duty  = t_duty;
        end
        if (fires)
            duty_q.push_back(duty);
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sender holds off until every expected result is out, then idles for the settle ticks
    // to cover any poll still in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (duty_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write of a batch.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        n_writes++;
        case (idx)
            CFG_OVR_RED:   ovr_colour.red   = val[7:0];
            CFG_OVR_GREEN: ovr_colour.green = val[7:0];
            CFG_OVR_BLUE:  ovr_colour.blue  = val[7:0];
            CFG_OVR_PACE:  ovr_pace         = val[PACE_W-1:0];
            CFG_IDLE_TMO:  idle_tmo         = val;
            default:       ;
        endcase
    endtask

    // Random polls in runs: each run holds one situation (idle, heating, hot, noise)
    // with jittered temperatures and a fixed receive time (noise runs scramble them), so colours
    // settle long enough for full breathing cycles, ramp-downs and counter wraps.
    task automatic random_phase(input int n_items, input int unsigned stride);
        int    sent;
        int    run_len;
        int    kind;
        int    base_bed;
        int    base_tgt;
        int    k;
        bit    cool;
        bit    pend;
        ms_t   rx;
        poll_t p;
        sent = 0;
        while (sent < n_items)
        begin
            run_len  = $urandom_range(1, 40);
            kind     = $urandom_range(0, 99);
            calm     = ($urandom_range(0, 9) == 0);
            cool     = $urandom_range(0, 1);
            pend     = ($urandom_range(0, 3) == 0);
            base_tgt = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4000);
            base_bed = 0;
            if (kind < 35)
            begin
                // nothing heating: mostly purple / green / white depending on receive age
                base_bed = $urandom_range(0, 800) - 400;
                base_tgt = 0;
                pend     = 1'b0;
            end
            else if (kind < 60)
                base_bed = $urandom_range(0, 4400) - 400;
            else if (kind < 75)
                base_bed = $urandom_range(501, 4000);
            case ($urandom_range(0, 9)) inside
                [0:2]: rx = '0;
                [3:6]: rx = cur_ms - $urandom_range(0, 50000);
                // receive age about to cross the purple window or the idle timeout
                7: rx = cur_ms - (45000 - $urandom_range(0, 400));
                8: rx = cur_ms - (idle_tmo - $urandom_range(0, 400));
                default: rx = $urandom;
            endcase
            for (k = 0; k < run_len && sent < n_items; k++)
            begin
                cur_ms += step_ms(stride);
                if (kind >= 75)
                    p = make_poll(cur_ms, $urandom, $urandom, $urandom_range(0, 1),
                                  $urandom_range(0, 1), $urandom_range(0, 1) ? $urandom : rx);
                else
                    p = make_poll(cur_ms, base_bed + $urandom_range(0, 6) - 3, base_tgt,
                                  cool, pend, rx);
                send_poll(p);
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls on m_tready, field checks on each accepted result.
    // Everything is sampled at the rising edge, before this edge's updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        colour_t got;
        colour_t want;
        level_t  got_v[3];
        level_t  want_v[3];
        string   chan[3];
        int      i;
        chan = '{"red_duty", "green_duty", "blue_duty"};
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            got = colour_t'{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]};
            if (duty_q.size() == 0)
            begin
                $error("result with none expected: red %0d green %0d blue %0d",
                       got.red, got.green, got.blue);
                n_fail++;
            end
            else
            begin
                want   = duty_q.pop_front();
                got_v  = '{got.red, got.green, got.blue};
                want_v = '{want.red, want.green, want.blue};
                for (i = 0; i < 3; i++)
                    if (got_v[i] != want_v[i])
                    begin
                        $error("%s: expected %0d, got %0d", chan[i], want_v[i], got_v[i]);
                        n_fail++;
                    end
            end
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            hold_left = pick_gap();
        end
    end

    // Watchdog: any request, result or register write resets the quiet count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("[rgb_status_glow_controller] ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        plan_row_t   plan[$];
        colour_t     o;
        logic [31:0] op;
        ms_t         it;
        int unsigned stride;
        int          ph;

        // Directed plan. The first four rows run from the reset state: white at
        // pace 30, so the first step needs more than 30 ms and reads curve entry 1.
        plan.push_back(poll_row(0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
        plan.push_back(poll_row(31, 0, 0, 0, 0, 0, 1'b1, 1'b1, colour_t'{8'd44, 8'd44, 8'd44}));
        plan.push_back(poll_row(61, 0, 0, 0, 0, 0, 1'b1, 1'b0));
        plan.push_back(poll_row(62, 0, 0, 0, 0, 0, 1'b1, 1'b1, colour_t'{8'd47, 8'd47, 8'd47}));
        // hottest code clamps the pace to its floor; just past the hot limit
        plan.push_back(poll_row(68, 4095, 0, 0, 0, 0));
        plan.push_back(poll_row(100, 501, 0, 0, 0, 0));
        // warm band: cooling blue at the hot limit, heating orange just over 40.0
        plan.push_back(poll_row(140, 500, 0, 1, 0, 0));
        plan.push_back(poll_row(180, 401, 0, 0, 0, 0));
        plan.push_back(poll_row(220, 400, 4095, 1, 0, 0));
        // most negative bed code, pending change: slowest hot pace
        plan.push_back(poll_row(300, -4096, 0, 0, 1, 0));
        // recent receive -> purple with quick change, then both window edges
        plan.push_back(poll_row(400, -400, 0, 0, 0, 300));
        plan.push_back(poll_row(45400, 0, 0, 0, 0, 401));
        plan.push_back(poll_row(45432, 0, 0, 0, 0, 432));
        plan.push_back(poll_row(60500, 0, 0, 0, 0, 501));
        plan.push_back(poll_row(61000, 0, 0, 0, 0, 1000));
        // receive time in the future: wrapped age, white
        plan.push_back(poll_row(32'hFFFF_FFF0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        // poll clock wraps past zero
        plan.push_back(poll_row(32'h0000_0020, 0, 0, 0, 0, 0));
        // override with zero pace: steps on any new time, never on a repeated one
        plan.push_back(cfg_row(CFG_OVR_RED, 32'd255));
        plan.push_back(cfg_row(CFG_OVR_PACE, 32'd0));
        plan.push_back(poll_row(100, 0, 0, 0, 0, 0));
        plan.push_back(poll_row(100, 0, 0, 0, 0, 0, 1'b1, 1'b0));
        plan.push_back(poll_row(101, 0, 0, 0, 0, 0));
        plan.push_back(cfg_row(CFG_OVR_RED, 32'd0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
                cfg_we <= 1'b0;
            end
            else
                send_poll(plan[i].poll, plan[i].typed, plan[i].fires, plan[i].duty);
        end
        cur_ms = 32'd200;

        // Random phases, each under its own register setting, extremes first.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    o = '0; op = 0; it = 32'd60000; stride = 40;
                end
                1:
                begin
                    o = colour_t'{8'd255, 8'd255, 8'd255}; op = 32'd32767; it = 0; stride = 40000;
                end
                2:
                begin
                    o = colour_t'{8'd0, 8'd0, 8'd1}; op = 0; it = 32'hFFFF_FFFF; stride = 4;
                end
                3:
                begin
                    o = '0; op = 32'd5; it = 0; stride = 40;
                end
                4:
                begin
                    o = '0; op = $urandom_range(0, 32767); it = $urandom_range(45000, 200000);
                    stride = 40;
                end
                default:
                begin
                    o = $urandom_range(1, 32'hFF_FFFF); op = $urandom_range(0, 60);
                    it = $urandom; stride = 80;
                end
            endcase
            // writes land only with the pipe empty
            settle();
            write_reg(CFG_OVR_RED, o.red);
            write_reg(CFG_OVR_GREEN, o.green);
            write_reg(CFG_OVR_BLUE, o.blue);
            write_reg(CFG_OVR_PACE, op);
            write_reg(CFG_IDLE_TMO, it);
            cfg_we <= 1'b0;
            random_phase(PHASE_ITEMS, stride);
        end

        settle();
        $display("run: %0d poll requests, %0d results, %0d register writes over %0d settings",
                 n_polls, n_results, n_writes, NUM_PHASES + 1);
        $display({"rules hit: override %0d hot %0d cool %0d heat %0d recent %0d ready %0d",
                  " idle %0d, ramp-down steps %0d"},
                 src_hits[SRC_OVR], src_hits[SRC_HOT], src_hits[SRC_COOL], src_hits[SRC_HEAT],
                 src_hits[SRC_RECENT], src_hits[SRC_READY], src_hits[SRC_IDLE], n_ramp);
        if (n_fail == 0)
            $display("[rgb_status_glow_controller] OK");
        else
            $display("[rgb_status_glow_controller] ERROR");
        $finish;
    end

endmodule
